### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in same-cycle check");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in next-cycle check");

`endif

### rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

	localparam int VALUE_WIDTH_DEF    = 32;
	localparam int MAX_DIGITS_OUT_DEF = 16;
	localparam int MIN_DIGITS_WIDTH   = 5;
	localparam int CHAR_WIDTH         = 6;

	localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;
	localparam logic [3:0]            DD_LIMIT   = 4'd5;
	localparam logic [3:0]            DD_ADJUST  = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### rtl/binary_to_decimal_ascii.sv
// Sequence: an accept state, a shift-and-adjust pass of the serial
// binary-to-BCD unit over every value bit, a sizing state, then one digit
// per cycle while out_stall is low. No new value is taken until the last
// digit of the previous value has been loaded into the output register.
// The shared double-dabble adjust and shift sets the conversion time.
// Reset: asynchronous, clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to decimal and sends its ASCII digits,
// most significant first, padded with leading zeros to min_digits, capped at MAX_DIGITS_OUT; zero sends one 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH    = b2da_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS_OUT = b2da_pkg::MAX_DIGITS_OUT_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [VALUE_WIDTH-1:0]                value,
	input  wire logic [b2da_pkg::MIN_DIGITS_WIDTH-1:0] min_digits,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [b2da_pkg::CHAR_WIDTH-1:0]            digit_char,
	output logic                                       last
);

	import b2da_pkg::*;

	localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_WIDTH  = 4 * BCD_DIGITS;
	localparam int DW         = $clog2(BCD_DIGITS);
	localparam int BW         = $clog2(VALUE_WIDTH);
	localparam int TMAX_A     = (BCD_DIGITS > MAX_DIGITS_OUT) ? BCD_DIGITS : MAX_DIGITS_OUT;
	localparam int TMAX       = (TMAX_A > 31) ? TMAX_A : 31;
	localparam int TW         = $clog2(TMAX + 1);

	localparam logic [TW-1:0] MAX_T    = TW'(MAX_DIGITS_OUT);
	localparam logic [TW-1:0] BCD_T    = TW'(BCD_DIGITS);
	localparam logic [TW-1:0] ONE_T    = TW'(1);
	localparam logic [BW-1:0] LAST_BIT = BW'(VALUE_WIDTH - 1);

	state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] val_q;
	logic [BCD_WIDTH-1:0]   bcd_q;
	logic [BW-1:0]          bit_cnt_q;
	logic [TW-1:0]          min_q;
	logic [TW-1:0]          pos_q;
	logic                   out_valid_q;
	logic [CHAR_WIDTH-1:0]  digit_char_q;
	logic                   last_q;

	logic                   accept;
	logic                   shift_en;
	logic                   size_en;
	logic                   load_out;

	logic [3:0]             digs [BCD_DIGITS];
	logic [BCD_WIDTH-1:0]   bcd_adj;
	logic [TW-1:0]          natural;
	logic [TW-1:0]          total;
	logic [TW-1:0]          min_ext;
	logic [TW-1:0]          min_clamp;
	logic [3:0]             sel_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		shift_en = 1'b0;
		size_en  = 1'b0;
		load_out = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				shift_en = 1'b1;
				if (bit_cnt_q == LAST_BIT) begin
					state_d = ST_SIZE;
				end
			end
			ST_SIZE: begin
				size_en = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					if (pos_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			digs[i] = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (digs[i] >= DD_LIMIT) ? (digs[i] + DD_ADJUST) : digs[i];
		end
	end

	always_comb begin
		natural = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (digs[i] != 4'd0) begin
				natural = TW'(i + 1);
			end
		end
		total = (natural > min_q) ? natural : min_q;
		if (total > MAX_T) begin
			total = MAX_T;
		end
		if (natural == '0) begin
			total = ONE_T;
		end
	end

	assign min_ext   = TW'(min_digits);
	assign min_clamp = (min_ext > MAX_T) ? MAX_T : min_ext;
	assign sel_digit = (pos_q < BCD_T) ? digs[pos_q[DW-1:0]] : 4'd0;

	// serial double-dabble unit
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q     <= value;
			bcd_q     <= '0;
			bit_cnt_q <= '0;
			min_q     <= min_clamp;
		end else if (shift_en) begin
			val_q     <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q     <= {bcd_adj[BCD_WIDTH-2:0], val_q[VALUE_WIDTH-1]};
			bit_cnt_q <= bit_cnt_q + BW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (size_en) begin
			pos_q <= total - ONE_T;
		end else if (load_out) begin
			pos_q <= pos_q - ONE_T;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			digit_char_q <= ASCII_ZERO + {2'b00, sel_digit};
			last_q       <= (pos_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;

	`ASSERT_NEXT(a_accept_starts_conv, accept, (state_q == ST_CONV) && (bcd_q == '0))
	`ASSERT_NEXT(a_conv_ends_in_size, (state_q == ST_CONV) && (bit_cnt_q == LAST_BIT),
		state_q == ST_SIZE)
	`ASSERT_NEXT(a_size_bounds_run, size_en, (state_q == ST_EMIT) && (pos_q < MAX_T))
	`ASSERT_NEXT(a_final_digit_flagged, load_out && (pos_q == '0),
		out_valid_q && last_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire
